FILE: hw/rtl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t FUNC_ADD = 2'd0;
	localparam func_t FUNC_SUB = 2'd1;
	localparam func_t FUNC_MUL = 2'd2;
	localparam func_t FUNC_DIV = 2'd3;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_ZERO_DEN = 2'd1;
	localparam status_t STAT_DIV_ZERO = 2'd2;

	localparam int NUM_OUT_W = 32;
	localparam int DEN_OUT_W = 31;

endpackage

FILE: hw/rtl/rau_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by rational_arith_unit for gcd and reduction.
`timescale 1ns / 1ps

module rau_div #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;
	logic [DW-1:0] rq_q;
	logic [DW-1:0] dv_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rq_q, dq_q[DW-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign ge    = !diff[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rq_q <= '0;
			dv_q <= divisor;
		end else if (cnt_q != '0) begin
			dq_q <= {dq_q[DW-2:0], ge};
			rq_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = dq_q;
	assign rem  = rq_q;

endmodule

FILE: hw/rtl/rational_arith_unit.sv
// Steps: the products on the shared multiplier, the sum and the sign, then the divides
// on the shared divider, one per Euclid step of the gcd plus two for the reduction,
// and last the result write.
// Throughput: one word at a time; s_axis_tready is low until the result word is taken.
// Operand errors skip the arithmetic and present the result in the cycle after the word is taken.
// Reset: arst_n clears the sequencer and the output valid at once.
// Top level: one shared multiplier and divider under a small sequencer; uses rau_pkg, rau_div.
`timescale 1ns / 1ps

module rational_arith_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// func, a_numerator, a_denominator, b_numerator, b_denominator
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// result_numerator, result_denominator
	output logic [63:0]                            m_axis_tdata,
	// status
	output logic [1:0]                             m_axis_tuser
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2*W + 2;
	localparam int DW = 2*W;
	localparam int RW = (DW > 32) ? DW : 32;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_SIGN, S_GCD, S_GCD_W,
		S_DIVN, S_DIVN_W, S_DIVD, S_DIVD_W, S_FIN, S_OUT
	} state_t;

	state_t            state_q;
	rau_pkg::func_t    func_q;
	logic signed [W-1:0] an_q, bn_q;
	logic [W-2:0]      ad_q, bd_q;
	logic signed [PW-1:0] t1_q, t2_q, t3_q, num_q, den_q;
	logic [DW-1:0]     a_q, b_q, un_q, ud_q;
	logic              neg_q;
	logic [rau_pkg::NUM_OUT_W-1:0] res_num_q;
	logic [rau_pkg::DEN_OUT_W-1:0] res_den_q;
	rau_pkg::status_t  status_q;

	rau_pkg::func_t    in_func;
	logic signed [W-1:0] in_an, in_bn;
	logic [W-2:0]      in_ad, in_bd;

	logic signed [W:0] mx, my;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] num_abs, den_abs;

	logic              div_start, div_done;
	logic [DW-1:0]     div_dvd, div_dvs, div_quot, div_rem;
	logic [RW-1:0]     ext_num, ext_den, sgn_num;

	assign in_func = s_axis_tdata[1:0];
	assign in_an   = s_axis_tdata[W+1:2];
	assign in_ad   = s_axis_tdata[2*W:W+2];
	assign in_bn   = s_axis_tdata[3*W:2*W+1];
	assign in_bd   = s_axis_tdata[4*W-1:3*W+1];

	always_comb begin
		mx = {an_q[W-1], an_q};
		my = $signed({2'b00, bd_q});
		case (state_q)
			S_MUL1: begin
				mx = {an_q[W-1], an_q};
				my = (func_q == rau_pkg::FUNC_MUL) ? {bn_q[W-1], bn_q} : $signed({2'b00, bd_q});
			end
			S_MUL2: begin
				mx = {bn_q[W-1], bn_q};
				my = $signed({2'b00, ad_q});
			end
			S_MUL3: begin
				mx = $signed({2'b00, ad_q});
				my = $signed({2'b00, bd_q});
			end
			default: ;
		endcase
	end

	assign prod    = PW'(mx * my);
	assign num_abs = num_q[PW-1] ? -num_q : num_q;
	assign den_abs = den_q[PW-1] ? -den_q : den_q;

	assign div_start = (state_q == S_GCD) || (state_q == S_DIVN) || (state_q == S_DIVD);
	assign div_dvd   = (state_q == S_DIVN) ? un_q : (state_q == S_DIVD) ? ud_q : a_q;
	assign div_dvs   = (state_q == S_GCD) ? b_q : a_q;

	rau_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign ext_num = RW'(un_q);
	assign ext_den = RW'(ud_q);
	assign sgn_num = neg_q ? -ext_num : ext_num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (in_ad == '0 || in_bd == '0) begin
							state_q <= S_OUT;
						end else if (in_func == rau_pkg::FUNC_DIV && in_bn == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1:   state_q <= S_MUL2;
				S_MUL2:   state_q <= S_MUL3;
				S_MUL3:   state_q <= S_SUM;
				S_SUM:    state_q <= S_SIGN;
				S_SIGN:   state_q <= S_GCD;
				S_GCD:    state_q <= S_GCD_W;
				S_GCD_W: begin
					if (div_done) begin
						state_q <= (div_rem == '0) ? S_DIVN : S_GCD;
					end
				end
				S_DIVN:   state_q <= S_DIVN_W;
				S_DIVN_W: if (div_done) state_q <= S_DIVD;
				S_DIVD:   state_q <= S_DIVD_W;
				S_DIVD_W: if (div_done) state_q <= S_FIN;
				S_FIN:    state_q <= S_OUT;
				S_OUT:    if (m_axis_tready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= in_func;
				an_q   <= in_an;
				ad_q   <= in_ad;
				bn_q   <= in_bn;
				bd_q   <= in_bd;
				res_num_q <= '0;
				res_den_q <= rau_pkg::DEN_OUT_W'(1);
				if (in_ad == '0 || in_bd == '0) begin
					status_q <= rau_pkg::STAT_ZERO_DEN;
				end else if (in_func == rau_pkg::FUNC_DIV && in_bn == '0) begin
					status_q <= rau_pkg::STAT_DIV_ZERO;
				end else begin
					status_q <= rau_pkg::STAT_OK;
				end
			end
			S_MUL1: t1_q <= prod;
			S_MUL2: t2_q <= prod;
			S_MUL3: t3_q <= prod;
			S_SUM: begin
				case (func_q)
					rau_pkg::FUNC_ADD: num_q <= t1_q + t2_q;
					rau_pkg::FUNC_SUB: num_q <= t1_q - t2_q;
					default:           num_q <= t1_q;
				endcase
				den_q <= (func_q == rau_pkg::FUNC_DIV) ? t2_q : t3_q;
			end
			S_SIGN: begin
				neg_q <= num_q[PW-1] ^ den_q[PW-1];
				un_q  <= num_abs[DW-1:0];
				ud_q  <= den_abs[DW-1:0];
				a_q   <= num_abs[DW-1:0];
				b_q   <= den_abs[DW-1:0];
			end
			S_GCD_W: begin
				if (div_done) begin
					a_q <= b_q;
					b_q <= div_rem;
				end
			end
			S_DIVN_W: if (div_done) un_q <= div_quot;
			S_DIVD_W: if (div_done) ud_q <= div_quot;
			S_FIN: begin
				res_num_q <= sgn_num[rau_pkg::NUM_OUT_W-1:0];
				res_den_q <= ext_den[rau_pkg::DEN_OUT_W-1:0];
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {1'b0, res_den_q, res_num_q};
	assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_q != rau_pkg::STAT_OK) |->
		(res_num_q == '0 && res_den_q == rau_pkg::DEN_OUT_W'(1)))
		else $error("error result not 0/1");
	a_gcd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD) |-> (b_q != '0))
		else $error("gcd step with zero divisor");
	a_reduce_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVN || state_q == S_DIVD) |-> (a_q != '0))
		else $error("reduction by zero gcd");
`endif

endmodule
